/* rtl/fdc_pkg.sv */
// ---------------------------------------------------------------------------
// fdc_pkg: shared types and constants of the floppy controller command phase
// Access kinds, register offsets, command opcodes, phase encoding and the
// decoded command record passed from the decoder to the top level.
// ---------------------------------------------------------------------------
package fdc_pkg;

    // Bus access kinds carried in the request tuser field
    localparam logic [1:0] ACC_WRITE = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_MEDIA = 2'd2;

    // Register offsets from the controller base
    localparam logic [2:0] OFS_DOR  = 3'd2;
    localparam logic [2:0] OFS_MSR  = 3'd4;
    localparam logic [2:0] OFS_DATA = 3'd5;
    localparam logic [2:0] OFS_DIR  = 3'd7;

    // Full-byte command opcodes
    localparam logic [7:0] OP_SPECIFY = 8'h03;
    localparam logic [7:0] OP_RECAL   = 8'h07;
    localparam logic [7:0] OP_SENSE   = 8'h08;
    localparam logic [7:0] OP_SEEK    = 8'h0F;
    // Low-bit opcode codes
    localparam logic [3:0] OP4_READ_ID   = 4'd10;
    localparam logic [4:0] OP5_READ_DATA = 5'd6;

    // Status values
    localparam logic [7:0] MSR_READY    = 8'h80;
    localparam logic [7:0] MSR_XMIT     = 8'hD0;
    localparam logic [7:0] DIR_CHANGED  = 8'h80;
    localparam logic [7:0] ST0_RESET    = 8'hC0;
    localparam logic [7:0] ST0_RECAL    = 8'h20;
    localparam logic [7:0] ST0_KEEP     = 8'h3F;
    localparam logic [7:0] ST0_ABNORMAL = 8'h40;
    localparam logic [7:0] ST1_NO_DATA  = 8'h04;
    localparam logic [7:0] READ_ID_N    = 8'h02;
    localparam logic [2:0] DOR_RESET_BIT = 3'd2;

    // Controller phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RECV = 3'b010,
        PH_XMIT = 3'b100
    } t_phase;

    // Command kinds that execute something
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SENSE,
        CMD_RECAL,
        CMD_SEEK,
        CMD_READ_ID,
        CMD_READ_DATA
    } t_cmd_kind;

    typedef struct packed {
        logic [3:0] length;
        t_cmd_kind  kind;
    } t_cmd_info;

endpackage

/* rtl/floppy_controller_command_phase.sv */
// ---------------------------------------------------------------------------
// floppy_controller_command_phase: host register interface of a floppy
// controller, command and result phases, one bus access per request.
// ---------------------------------------------------------------------------
// Path: an accepted request is held in the input register, and its result
//   is loaded into the result register once that register is free or drains.
// Throughput: one request per cycle unless i_m_tready stalls the result;
//   all decode and queue update is one combinational pass between the two registers.
// Reset: i_rst_n synchronous, active low; clears control state, the byte
//   queue keeps its contents and is rewritten before any read of it.
module floppy_controller_command_phase #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // port_offset[2:0], write_data[10:3], media_fault[11]
    input  logic [1:0]  i_s_tuser,   // opcode[1:0]
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // read_data[7:0], irq_pulse[8]
);
    import fdc_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [4:0] DEPTH5 = 5'(QUEUE_DEPTH);

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [2:0]  r_in_port;
    logic [7:0]  r_in_wdata;
    logic        r_in_fault;
    // Result register
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_irq;
    // Controller state
    logic [7:0]  r_dor,    n_dor;
    t_phase      r_phase,  n_phase;
    logic [4:0]  r_write_count, n_write_count;
    logic [4:0]  r_read_index,  n_read_index;
    logic [4:0]  r_result_count, n_result_count;
    logic [7:0]  r_st0,    n_st0;
    logic        r_media,  n_media;
    logic [7:0]  r_queue [QUEUE_DEPTH];
    logic [7:0]  n_queue [QUEUE_DEPTH];
    logic [7:0]  n_rd;
    logic        n_irq;

    logic        advance;
    logic        data_wr;
    logic [4:0]  wc_eff;
    logic [4:0]  wc_next;
    logic [7:0]  op_byte;
    t_cmd_info   cmd;
    logic        complete;
    logic [7:0]  res_byte [7];
    logic [4:0]  res_count;
    logic        res_irq;
    logic [7:0]  st0_exec;

    // Move a request forward when the result register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_op    <= i_s_tuser;
            r_in_port  <= i_s_tdata[2:0];
            r_in_wdata <= i_s_tdata[10:3];
            r_in_fault <= i_s_tdata[11];
        end
    end

    // Command byte collection
    assign data_wr = (r_in_op == ACC_WRITE) && (r_in_port == OFS_DATA) && (r_phase != PH_XMIT);
    assign wc_eff  = (r_phase == PH_IDLE) ? 5'd0 : r_write_count;
    assign wc_next = 5'(wc_eff + 5'd1);
    assign op_byte = (wc_eff == 5'd0) ? r_in_wdata : r_queue[0];

    fdc_cmd_decode u_decode (
        .i_opcode (op_byte),
        .o_info   (cmd)
    );

    assign complete = data_wr && ({1'b0, cmd.length} == wc_next);

    // Result bytes of the command that completes
    always_comb begin
        logic [7:0] q_after [QUEUE_DEPTH];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_after[i] = (data_wr && wc_eff < DEPTH5 && wc_eff[AW-1:0] == AW'(i))
                         ? r_in_wdata : r_queue[i];
        end
        for (int i = 0; i < 7; i++) begin
            res_byte[i] = 8'h00;
        end
        res_count = 5'd0;
        res_irq   = 1'b0;
        st0_exec  = r_st0;
        case (cmd.kind)
            CMD_SENSE: begin
                res_byte[0] = r_st0;
                res_count   = 5'd2;
            end
            CMD_RECAL: begin
                st0_exec = ST0_RECAL;
                res_irq  = 1'b1;
            end
            CMD_SEEK: begin
                res_irq = 1'b1;
            end
            CMD_READ_ID: begin
                res_byte[0] = r_st0;
                res_byte[6] = READ_ID_N;
                res_count   = 5'd7;
                res_irq     = 1'b1;
            end
            CMD_READ_DATA: begin
                if (r_in_fault) begin
                    st0_exec    = (r_st0 & ST0_KEEP) | ST0_ABNORMAL;
                    res_byte[1] = ST1_NO_DATA;
                end
                res_byte[0] = st0_exec;
                res_byte[3] = q_after[2];
                res_byte[4] = q_after[3];
                res_byte[5] = q_after[4];
                res_byte[6] = q_after[5];
                res_count   = 5'd7;
                res_irq     = 1'b1;
            end
            default: begin
                res_count = 5'd0;
            end
        endcase
        // Queue: written byte first, then results overwrite the front
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_queue[i] = q_after[i];
        end
        if (complete) begin
            for (int i = 0; i < 7; i++) begin
                if (5'(i) < res_count) begin
                    n_queue[i] = res_byte[i];
                end
            end
        end
    end

    // Access execution
    always_comb begin
        n_dor          = r_dor;
        n_phase        = r_phase;
        n_write_count  = r_write_count;
        n_read_index   = r_read_index;
        n_result_count = r_result_count;
        n_st0          = r_st0;
        n_media        = r_media;
        n_rd           = 8'h00;
        n_irq          = 1'b0;
        case (r_in_op)
            ACC_WRITE: begin
                if (r_in_port == OFS_DOR) begin
                    // Rising reset bit returns the controller to its reset state
                    if (!r_dor[DOR_RESET_BIT] && r_in_wdata[DOR_RESET_BIT]) begin
                        n_phase        = PH_IDLE;
                        n_write_count  = 5'd0;
                        n_read_index   = 5'd0;
                        n_result_count = 5'd0;
                        n_st0          = ST0_RESET;
                        n_media        = 1'b0;
                        n_irq          = 1'b1;
                    end
                    n_dor = r_in_wdata;
                end else if (data_wr) begin
                    n_write_count = wc_next;
                    n_phase       = PH_RECV;
                    if (complete) begin
                        n_read_index   = 5'd0;
                        n_result_count = res_count;
                        n_st0          = st0_exec;
                        n_irq          = res_irq;
                        n_phase        = (res_count != 5'd0) ? PH_XMIT : PH_IDLE;
                        if (cmd.kind == CMD_SEEK) begin
                            n_media = 1'b0;
                        end
                    end
                end
            end
            ACC_READ: begin
                if (r_in_port == OFS_MSR) begin
                    n_rd = (r_phase == PH_XMIT) ? MSR_XMIT : MSR_READY;
                end else if (r_in_port == OFS_DATA) begin
                    // Hand out the next result byte, go idle after the last
                    if (r_phase == PH_XMIT && r_read_index < r_result_count) begin
                        n_rd         = r_queue[r_read_index[AW-1:0]];
                        n_read_index = 5'(r_read_index + 5'd1);
                        if (n_read_index == r_result_count) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end else if (r_in_port == OFS_DIR) begin
                    n_rd = r_media ? DIR_CHANGED : 8'h00;
                end
            end
            ACC_MEDIA: begin
                n_media = 1'b1;
            end
            default: begin
                n_rd = 8'h00;
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dor          <= 8'h00;
            r_phase        <= PH_IDLE;
            r_write_count  <= 5'd0;
            r_read_index   <= 5'd0;
            r_result_count <= 5'd0;
            r_st0          <= ST0_RESET;
            r_media        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (advance) begin
                r_dor          <= n_dor;
                r_phase        <= n_phase;
                r_write_count  <= n_write_count;
                r_read_index   <= n_read_index;
                r_result_count <= n_result_count;
                r_st0          <= n_st0;
                r_media        <= n_media;
                r_out_valid    <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_rd;
            r_out_irq  <= n_irq;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_queue[i] <= n_queue[i];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_irq, r_out_data};

    // Transmit phase always has result bytes left to hand out
    a_xmit_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_XMIT |-> r_read_index < r_result_count)
        else $error("transmit phase with no pending result");

    // Receive phase holds a partial command of at most eight bytes
    a_recv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RECV |-> (r_write_count != 5'd0 && r_write_count < 5'd9))
        else $error("receive count out of range");

    // A processed request always lands in the result register
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed request lost");

    // The result count never exceeds the longest result list
    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_count <= 5'd7)
        else $error("result count out of range");

endmodule

/* rtl/fdc_cmd_decode.sv */
// ---------------------------------------------------------------------------
// fdc_cmd_decode: command opcode decoder
// Gives the number of bytes a command takes and the kind of work it runs.
// ---------------------------------------------------------------------------
module fdc_cmd_decode (
    input  logic [7:0]         i_opcode,
    output fdc_pkg::t_cmd_info o_info
);
    import fdc_pkg::*;

    always_comb begin
        // Length from the low five opcode bits
        case (i_opcode[4:0]) inside
            5'd5, 5'd6:   o_info.length = 4'd9;
            5'd7, 5'd10:  o_info.length = 4'd2;
            5'd13:        o_info.length = 4'd6;
            5'd3, 5'd15:  o_info.length = 4'd3;
            5'd19:        o_info.length = 4'd7;
            default:      o_info.length = 4'd1;
        endcase

        // Kind by priority: exact opcodes first, then the masked families
        if (i_opcode == OP_SENSE) begin
            o_info.kind = CMD_SENSE;
        end else if (i_opcode == OP_SPECIFY) begin
            o_info.kind = CMD_NONE;
        end else if (i_opcode == OP_RECAL) begin
            o_info.kind = CMD_RECAL;
        end else if (i_opcode == OP_SEEK) begin
            o_info.kind = CMD_SEEK;
        end else if (i_opcode[3:0] == OP4_READ_ID) begin
            o_info.kind = CMD_READ_ID;
        end else if (i_opcode[4:0] == OP5_READ_DATA) begin
            o_info.kind = CMD_READ_DATA;
        end else begin
            o_info.kind = CMD_NONE;
        end
    end

endmodule
